FILE: design/trvm_pkg.sv
// Shared types, widths and constants of the true RMS voltage meter.
package trvm_pkg;

	localparam int unsigned SAMPLE_BITS_DEF = 12;
	localparam int unsigned GAIN_W          = 16;
	localparam int unsigned CAL_W           = 20;
	localparam int unsigned CNT_W           = 16;
	localparam int unsigned SUM_W           = 40;
	localparam int unsigned SMOOTH_W        = 32;
	localparam int unsigned VOLT_W          = 16;
	localparam int unsigned ROOT_W          = 28;
	localparam int unsigned DIVIDEND_W      = SUM_W + 16;
	localparam int unsigned REM_W           = 32;
	localparam int unsigned MUL_A_W         = 32;
	localparam int unsigned MUL_B_W         = 20;
	localparam int unsigned ACC_W           = 53;
	localparam int unsigned CFG_INDEX_W     = 8;
	localparam int unsigned CFG_DATA_W      = 20;

	localparam logic [16:0]      Q16_ONE  = 17'h10000;
	localparam logic [ACC_W-1:0] Q16_HALF = ACC_W'(32768);
	localparam logic [ACC_W-1:0] Q8_HALF  = ACC_W'(128);

	localparam logic [CNT_W-1:0]  WINDOW_LENGTH_RST    = 16'd4000;
	localparam logic [GAIN_W-1:0] OFFSET_GAIN_RST      = 16'd66;
	localparam logic [GAIN_W-1:0] SMOOTH_GAIN_RST      = 16'd13107;
	localparam logic [CAL_W-1:0]  CALIBRATION_GAIN_RST = 20'd38076;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WINDOW_LENGTH    = 8'd0,
		REG_OFFSET_GAIN      = 8'd1,
		REG_SMOOTH_GAIN      = 8'd2,
		REG_CALIBRATION_GAIN = 8'd3
	} trvm_reg_t;

	typedef enum logic {
		MODE_DIV,
		MODE_SQRT
	} trvm_mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_OFF_A,
		S_OFF_B,
		S_OFF_WB,
		S_SQ,
		S_ACC,
		S_DIV_GO,
		S_DIV_WAIT,
		S_SQRT_GO,
		S_SQRT_WAIT,
		S_CAL,
		S_CAL_WB,
		S_SM_A,
		S_SM_B,
		S_SM_WB,
		S_OUT
	} trvm_state_t;

	typedef struct packed {
		logic en;
		logic load;
	} trvm_mac_ctl_t;

	typedef struct packed {
		logic       start;
		trvm_mode_t mode;
	} trvm_unit_req_t;

endpackage

FILE: design/trvm_if.sv
// Valid/ready channel interfaces for samples, voltages and register writes.
interface trvm_sample_if import trvm_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface trvm_voltage_if import trvm_pkg::*;;
	logic              valid;
	logic              ready;
	logic [VOLT_W-1:0] voltage;

	modport source(output valid, output voltage, input ready);
	modport sink(input valid, input voltage, output ready);
endinterface

interface trvm_cfg_if import trvm_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: design/trvm_mac.sv
// Shared multiply-accumulate unit used for every product of the meter.
module trvm_mac import trvm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  trvm_mac_ctl_t      ctl,
	input  logic [ACC_W-1:0]   bias,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [ACC_W-1:0]   acc
);

	logic [MUL_A_W+MUL_B_W-1:0] product;
	logic [ACC_W-1:0]           acc_q;

	assign product = a * b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= (ctl.load ? bias : acc_q) + ACC_W'(product);
		end
	end

	assign acc = acc_q;

endmodule

FILE: design/trvm_shift_sub.sv
// Iterative shift-subtract unit: restoring divider and digit-by-digit square root.
module trvm_shift_sub import trvm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  trvm_unit_req_t        req,
	input  logic [DIVIDEND_W-1:0] operand,
	input  logic [CNT_W-1:0]      divisor,
	output logic [DIVIDEND_W-1:0] result,
	output logic                  done
);

	localparam int unsigned STEP_W = $clog2(DIVIDEND_W);

	logic [DIVIDEND_W-1:0] x_q;
	logic [DIVIDEND_W-1:0] q_q;
	logic [REM_W-1:0]      rem_q;
	logic [CNT_W-1:0]      d_q;
	trvm_mode_t            mode_q;
	logic [STEP_W-1:0]     cnt_q;
	logic                  run_q;
	logic                  done_q;

	logic [REM_W-1:0]      rem_sh;
	logic [REM_W-1:0]      trial;
	logic [DIVIDEND_W-1:0] x_next;
	logic                  ge;

	// One compare and subtract per cycle; the divider brings in one dividend bit,
	// the root brings in two radicand bits against the trial value 4*root+1.
	always_comb begin
		if (mode_q == MODE_SQRT) begin
			rem_sh = {rem_q[REM_W-3:0], x_q[DIVIDEND_W-1 -: 2]};
			trial  = {q_q[REM_W-3:0], 2'b01};
			x_next = {x_q[DIVIDEND_W-3:0], 2'b00};
		end else begin
			rem_sh = {rem_q[REM_W-2:0], x_q[DIVIDEND_W-1]};
			trial  = REM_W'(d_q);
			x_next = {x_q[DIVIDEND_W-2:0], 1'b0};
		end
		ge = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= (req.mode == MODE_SQRT) ? STEP_W'(DIVIDEND_W / 2 - 1)
					: STEP_W'(DIVIDEND_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= operand;
			q_q    <= '0;
			rem_q  <= '0;
			d_q    <= divisor;
			mode_q <= req.mode;
		end else if (run_q) begin
			x_q   <= x_next;
			q_q   <= {q_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? (rem_sh - trial) : rem_sh;
		end
	end

	assign result = q_q;
	assign done   = done_q;

endmodule

FILE: design/true_rms_voltage_meter.sv
// True RMS voltage meter: offset tracking, windowed mean square, root, calibration and smoothing.
// A sample that does not close a window steps through S_OFF_A to S_ACC before ready returns.
// A sample that closes a window has its voltage made valid after the 56 divider steps and
// 28 root steps of the shared shift-subtract unit and 6 MAC steps.
// The output register lets the next sample transfer while a voltage waits to be taken.
// Asynchronous active-low reset restores state, settings, sums and the offset of half scale.
module true_rms_voltage_meter import trvm_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	trvm_sample_if.sink     samples,
	trvm_voltage_if.source  voltages,
	trvm_cfg_if.sink        cfg
);

	localparam int unsigned OFF_W = SAMPLE_BITS + 16;
	localparam int unsigned SQ_W  = 2 * SAMPLE_BITS;
	localparam logic [OFF_W-1:0] OFF_RESET = OFF_W'(1) << (SAMPLE_BITS + 15);

	trvm_state_t state_q, state_d;

	logic [CNT_W-1:0]  window_length_q;
	logic [GAIN_W-1:0] offset_gain_q;
	logic [GAIN_W-1:0] smooth_gain_q;
	logic [CAL_W-1:0]  calibration_gain_q;

	logic [SAMPLE_BITS-1:0] sample_q;
	logic [OFF_W-1:0]       offset_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       count_q;
	logic [SMOOTH_W-1:0]    smoothed_q;
	logic [SMOOTH_W-1:0]    value_q;
	logic [VOLT_W-1:0]      voltage_q;
	logic                   out_valid_q;

	trvm_mac_ctl_t          mac_ctl;
	logic [ACC_W-1:0]       mac_bias;
	logic [MUL_A_W-1:0]     mac_a;
	logic [MUL_B_W-1:0]     mac_b;
	logic [ACC_W-1:0]       mac_acc;

	trvm_unit_req_t         unit_req;
	logic [DIVIDEND_W-1:0]  unit_operand;
	logic [DIVIDEND_W-1:0]  unit_result;
	logic                   unit_done;

	logic [SAMPLE_BITS-1:0] base;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SUM_W:0]         sum_ext;
	logic [CNT_W-1:0]       count_next;
	logic [SMOOTH_W-1:0]    smooth_src;
	logic [SMOOTH_W-1:0]    value_sat;
	logic [SMOOTH_W:0]      volts_ext;
	logic                   out_free;

	assign base       = offset_q[OFF_W-1:16];
	assign mag        = (sample_q >= base) ? (sample_q - base) : (base - sample_q);
	assign sum_ext    = {1'b0, sum_q} + (SUM_W + 1)'(mac_acc[SQ_W-1:0]);
	assign count_next = count_q + 1'b1;
	assign smooth_src = (smoothed_q == '0) ? value_q : smoothed_q;
	assign value_sat  = (|mac_acc[ACC_W-1:SMOOTH_W+8]) ? '1 : mac_acc[SMOOTH_W+7:8];
	assign volts_ext  = {1'b0, smoothed_q} + (SMOOTH_W + 1)'(32768);
	assign out_free   = !out_valid_q || voltages.ready;

	assign cfg.ready        = 1'b1;
	assign voltages.valid   = out_valid_q;
	assign voltages.voltage = voltage_q;

	trvm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.bias   (mac_bias),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (mac_acc)
	);

	trvm_shift_sub u_shift_sub (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (unit_req),
		.operand (unit_operand),
		.divisor (count_q),
		.result  (unit_result),
		.done    (unit_done)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (samples.valid) state_d = S_OFF_A;
			S_OFF_A:     state_d = S_OFF_B;
			S_OFF_B:     state_d = S_OFF_WB;
			S_OFF_WB:    state_d = S_SQ;
			S_SQ:        state_d = S_ACC;
			S_ACC:       state_d = (count_next < window_length_q) ? S_IDLE : S_DIV_GO;
			S_DIV_GO:    state_d = S_DIV_WAIT;
			S_DIV_WAIT:  if (unit_done) state_d = S_SQRT_GO;
			S_SQRT_GO:   state_d = S_SQRT_WAIT;
			S_SQRT_WAIT: if (unit_done) state_d = S_CAL;
			S_CAL:       state_d = S_CAL_WB;
			S_CAL_WB:    state_d = S_SM_A;
			S_SM_A:      state_d = S_SM_B;
			S_SM_B:      state_d = S_SM_WB;
			S_SM_WB:     state_d = S_OUT;
			S_OUT:       if (out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		samples.ready = 1'b0;
		mac_ctl       = '0;
		mac_bias      = '0;
		mac_a         = '0;
		mac_b         = '0;
		unit_req      = '{start: 1'b0, mode: MODE_DIV};
		unit_operand  = '0;
		case (state_q)
			S_IDLE: begin
				samples.ready = 1'b1;
			end
			S_OFF_A: begin
				mac_ctl  = '{en: 1'b1, load: 1'b1};
				mac_bias = Q16_HALF;
				mac_a    = MUL_A_W'(offset_q);
				mac_b    = MUL_B_W'(Q16_ONE - {1'b0, offset_gain_q});
			end
			S_OFF_B: begin
				mac_ctl = '{en: 1'b1, load: 1'b0};
				mac_a   = MUL_A_W'({sample_q, 16'b0});
				mac_b   = MUL_B_W'(offset_gain_q);
			end
			S_SQ: begin
				mac_ctl = '{en: 1'b1, load: 1'b1};
				mac_a   = MUL_A_W'(mag);
				mac_b   = MUL_B_W'(mag);
			end
			S_DIV_GO: begin
				unit_req     = '{start: 1'b1, mode: MODE_DIV};
				unit_operand = {sum_q, 16'b0};
			end
			S_SQRT_GO: begin
				// A window that closes with a wrapped count of zero has a mean square of zero.
				unit_req     = '{start: 1'b1, mode: MODE_SQRT};
				unit_operand = (count_q == '0) ? '0 : unit_result;
			end
			S_CAL: begin
				mac_ctl  = '{en: 1'b1, load: 1'b1};
				mac_bias = Q8_HALF;
				mac_a    = MUL_A_W'(unit_result[ROOT_W-1:0]);
				mac_b    = MUL_B_W'(calibration_gain_q);
			end
			S_SM_A: begin
				mac_ctl  = '{en: 1'b1, load: 1'b1};
				mac_bias = Q16_HALF;
				mac_a    = MUL_A_W'(smooth_src);
				mac_b    = MUL_B_W'(Q16_ONE - {1'b0, smooth_gain_q});
			end
			S_SM_B: begin
				mac_ctl = '{en: 1'b1, load: 1'b0};
				mac_a   = MUL_A_W'(value_q);
				mac_b   = MUL_B_W'(smooth_gain_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= S_IDLE;
			window_length_q    <= WINDOW_LENGTH_RST;
			offset_gain_q      <= OFFSET_GAIN_RST;
			smooth_gain_q      <= SMOOTH_GAIN_RST;
			calibration_gain_q <= CALIBRATION_GAIN_RST;
			offset_q           <= OFF_RESET;
			sum_q              <= '0;
			count_q            <= '0;
			smoothed_q         <= '0;
			out_valid_q        <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg.valid) begin
				case (cfg.index)
					REG_WINDOW_LENGTH:    window_length_q    <= cfg.data[CNT_W-1:0];
					REG_OFFSET_GAIN:      offset_gain_q      <= cfg.data[GAIN_W-1:0];
					REG_SMOOTH_GAIN:      smooth_gain_q      <= cfg.data[GAIN_W-1:0];
					REG_CALIBRATION_GAIN: calibration_gain_q <= cfg.data[CAL_W-1:0];
					default: begin
					end
				endcase
			end

			case (state_q)
				S_OFF_WB: offset_q <= mac_acc[OFF_W+15:16];
				S_ACC: begin
					sum_q   <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
					count_q <= count_next;
				end
				S_SM_WB: smoothed_q <= mac_acc[SMOOTH_W+15:16];
				S_OUT: begin
					if (out_free) begin
						sum_q   <= '0;
						count_q <= '0;
					end
				end
				default: begin
				end
			endcase

			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (voltages.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && samples.valid) begin
			sample_q <= samples.sample;
		end
		if (state_q == S_CAL_WB) begin
			value_q <= value_sat;
		end
		if (state_q == S_OUT && out_free) begin
			voltage_q <= volts_ext[SMOOTH_W] ? '1 : volts_ext[SMOOTH_W-1:16];
		end
	end

endmodule

FILE: design/trvm_checker.sv
// Port-level checks of the RMS meter, attached to the top level by bind.
module trvm_checker import trvm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_ready,
	input logic              volt_valid,
	input logic              volt_ready,
	input logic [VOLT_W-1:0] voltage
);

	// No voltage is offered while reset is asserted.
	assert property (@(posedge clk) !arst_n |-> !volt_valid)
		else $error("voltage valid during reset");

	// Each sample keeps the block busy, so ready drops right after a transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample accepted while previous one still in progress");

	// A new voltage never follows a sample transfer in the very next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(volt_valid) |-> !$past(sample_valid && sample_ready))
		else $error("voltage appeared too soon after a sample transfer");

	// A stalled voltage keeps its value until the transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		volt_valid && !volt_ready |=> volt_valid && $stable(voltage))
		else $error("stalled voltage changed or was dropped");

endmodule

bind true_rms_voltage_meter trvm_checker u_trvm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (samples.valid),
	.sample_ready (samples.ready),
	.volt_valid   (voltages.valid),
	.volt_ready   (voltages.ready),
	.voltage      (voltages.voltage)
);
